### src/mret_pkg.sv
// Shared types and constants for the most-recent-event top-k block.
// Used by mret_cell, mret_chain and most_recent_event_top_k_top.
`default_nettype none

package mret_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_W        = 10;
    localparam int STAMP_W     = 64;
    localparam int SLOT_W      = 4;
    localparam int TOTAL_W     = 5;
    localparam int RUN_MAX     = 16;
    localparam int ACT_W       = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 88;

    typedef enum logic [ACT_W-1:0] {
        ACT_START = 2'd0,
        ACT_OFFER = 2'd1,
        ACT_EMIT  = 2'd2,
        ACT_PROBE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_CLEAR  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } cell_t;

    typedef struct packed {
        cell_op_t           op;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

endpackage

`default_nettype wire

### src/mret_cell.sv
// One cell of the sorted event row: holds one entry and its occupancy bit.
// Depends on mret_pkg for the cell and control types.
`default_nettype none

module mret_cell
    import mret_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire cell_t      prev,
    input  wire logic       prev_ge,
    input  wire cell_t      next,
    output cell_t           cur,
    output logic            ge
);

    logic               valid_reg, valid_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;

    // An occupied entry that is not older than the offered stamp stays ahead of it.
    assign ge = valid_reg && (stamp_reg >= ctrl.stamp);

    assign cur.valid = valid_reg;
    assign cur.id    = id_reg;
    assign cur.stamp = stamp_reg;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        stamp_next = stamp_reg;
        case (ctrl.op)
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            CELL_INSERT:
            begin
                if (!prev_ge)
                begin
                    valid_next = prev.valid;
                    id_next    = prev.id;
                    stamp_next = prev.stamp;
                end
                else if (!ge)
                begin
                    valid_next = 1'b1;
                    id_next    = ctrl.id;
                    stamp_next = ctrl.stamp;
                end
            end
            CELL_ROTATE:
            begin
                valid_next = next.valid;
                id_next    = next.id;
                stamp_next = next.stamp;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        stamp_reg <= stamp_next;
    end

endmodule

`default_nettype wire

### src/mret_chain.sv
// Row of DEPTH cells kept sorted newest first; also rotates as a ring.
// Depends on mret_pkg and mret_cell.
`default_nettype none

module mret_chain
    import mret_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    output cell_t           head
);

    cell_t cells [DEPTH];
    logic  ges   [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_t prev_c;
            logic  prev_g;
            cell_t next_c;

            if (i == 0)
            begin : g_first
                assign prev_c = '0;
                assign prev_g = 1'b1;
            end
            else
            begin : g_rest
                assign prev_c = cells[i-1];
                assign prev_g = ges[i-1];
            end

            // The last cell closes the ring so a full rotation restores the list.
            if (i == DEPTH - 1)
            begin : g_wrap
                assign next_c = cells[0];
            end
            else
            begin : g_link
                assign next_c = cells[i+1];
            end

            mret_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .prev    (prev_c),
                .prev_ge (prev_g),
                .next    (next_c),
                .cur     (cells[i]),
                .ge      (ges[i])
            );
        end
    endgenerate

    assign head = cells[0];

endmodule

`default_nettype wire

### src/most_recent_event_top_k_top.sv
// Most-recent-event top-k: start and offer requests give no result.
// A probe or an empty-list emit gives its single result in the cycle after acceptance.
// An emit on a non-empty list rotates the cell ring once, giving one result per cycle
// when unstalled, for the first min(count, 16) entries; no request is taken meanwhile.
// Reset (rst_n low, asynchronous) empties the list and zeroes the recorded stamp.
// Depends on mret_pkg and mret_chain.
`default_nettype none

module most_recent_event_top_k_top
    import mret_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // event_id[9:0], stamp[73:10], has_occurred[74], zero fill above
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  wire logic [ACT_W-1:0]       s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // slot[3:0], total[8:4], entry_id[18:9], entry_stamp[82:19], newer[83], zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // entry_valid[0]
    output logic [0:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [STAMP_W-1:0] newest_reg, newest_next;
    logic [CW-1:0]      step_reg, step_next;
    logic [TOTAL_W-1:0] n_reg, n_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [STAMP_W-1:0] out_stamp_reg, out_stamp_next;
    logic               out_ev_reg, out_ev_next;
    logic               out_newer_reg, out_newer_next;
    logic               out_last_reg, out_last_next;

    action_t            act;
    logic [ID_W-1:0]    in_id;
    logic [STAMP_W-1:0] in_stamp;
    logic               in_occ;
    logic               s_hs;
    logic               out_free;
    logic               advance;
    logic               produce;
    logic               step_done;
    cell_ctrl_t         ctrl;
    cell_t              head;

    assign act      = action_t'(s_axis_tuser);
    assign in_id    = s_axis_tdata[ID_W-1:0];
    assign in_stamp = s_axis_tdata[ID_W+STAMP_W-1:ID_W];
    assign in_occ   = s_axis_tdata[ID_W+STAMP_W];

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s_hs      = s_axis_tvalid && s_axis_tready;
    assign step_done = (step_reg == CW'(DEPTH - 1));

    mret_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .head  (head)
    );

    // Handshake and cell control.
    always_comb
    begin
        s_axis_tready = 1'b0;
        advance       = 1'b0;
        produce       = 1'b0;
        ctrl.op       = CELL_HOLD;
        ctrl.id       = in_id;
        ctrl.stamp    = in_stamp;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = out_free || (act == ACT_START) || (act == ACT_OFFER);
                // Start and offer requests are always ready here, so tvalid alone
                // marks their acceptance.
                if (s_axis_tvalid && (act == ACT_START))
                begin
                    ctrl.op = CELL_CLEAR;
                end
                else if (s_axis_tvalid && (act == ACT_OFFER) && in_occ)
                begin
                    ctrl.op = CELL_INSERT;
                end
            end
            ST_EMIT:
            begin
                produce = out_free && (32'(step_reg) < 32'(n_reg));
                advance = out_free || (32'(step_reg) >= 32'(n_reg));
                if (advance)
                begin
                    ctrl.op = CELL_ROTATE;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_hs && (act == ACT_EMIT) && (count_reg != '0))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (advance && step_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath registers and the output stage.
    always_comb
    begin
        count_next     = count_reg;
        newest_next    = newest_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_slot_next  = out_slot_reg;
        out_total_next = out_total_reg;
        out_id_next    = out_id_reg;
        out_stamp_next = out_stamp_reg;
        out_ev_next    = out_ev_reg;
        out_newer_next = out_newer_reg;
        out_last_next  = out_last_reg;

        if (s_hs)
        begin
            case (act)
                ACT_START:
                begin
                    count_next = '0;
                end
                ACT_OFFER:
                begin
                    if (in_occ && (count_reg < CW'(DEPTH)))
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_EMIT:
                begin
                    step_next  = '0;
                    total_next = TOTAL_W'(count_reg);
                    n_next     = (32'(count_reg) > RUN_MAX) ? TOTAL_W'(RUN_MAX)
                                                            : TOTAL_W'(count_reg);
                    if (count_reg == '0)
                    begin
                        newest_next    = '0;
                        out_valid_next = 1'b1;
                        out_slot_next  = '0;
                        out_total_next = '0;
                        out_id_next    = '0;
                        out_stamp_next = '0;
                        out_ev_next    = 1'b0;
                        out_newer_next = 1'b0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        newest_next = head.stamp;
                    end
                end
                ACT_PROBE:
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = '0;
                    out_total_next = '0;
                    out_id_next    = '0;
                    out_stamp_next = '0;
                    out_ev_next    = 1'b0;
                    out_newer_next = in_occ && (in_stamp > newest_reg);
                    out_last_next  = 1'b1;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        if (advance)
        begin
            step_next = step_reg + CW'(1);
        end

        // The head cell carries the entry for the current slot while the ring turns.
        if (produce)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = SLOT_W'(step_reg);
            out_total_next = total_reg;
            out_id_next    = head.id;
            out_stamp_next = head.stamp;
            out_ev_next    = 1'b1;
            out_newer_next = 1'b0;
            out_last_next  = ((32'(step_reg) + 32'd1) == 32'(n_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            newest_reg    <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            newest_reg    <= newest_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        total_reg     <= total_next;
        out_slot_reg  <= out_slot_next;
        out_total_reg <= out_total_next;
        out_id_reg    <= out_id_next;
        out_stamp_reg <= out_stamp_next;
        out_ev_reg    <= out_ev_next;
        out_newer_reg <= out_newer_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_newer_reg, out_stamp_reg, out_id_reg,
                            out_total_reg, out_slot_reg};
    assign m_axis_tuser  = out_ev_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("entry count exceeds the row depth");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (head.valid == (count_reg != '0)))
        else $error("head cell occupancy disagrees with the entry count");

    a_no_request_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !s_axis_tready)
        else $error("request accepted while the ring rotates");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_hs && (act == ACT_START)) |=> (count_reg == '0))
        else $error("start request did not empty the list");
`endif

endmodule

`default_nettype wire
